@@ rtl/assert_macros.svh @@
// Assertion macros for the line edge run ratio block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define LERR_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");
`define LERR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define LERR_ASSERT_ALWAYS(lbl, expr)
`define LERR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/lerr_pkg.sv @@
// Types, constants and functions shared by the line edge run ratio block.
package lerr_pkg;
	localparam int MAX_LINE_PIXELS = 4096;
	localparam int TOP_RUNS        = 3;
	localparam int RATIO_FRAC_BITS = 16;

	localparam int CNT_W   = $clog2(MAX_LINE_PIXELS + 1);
	localparam int SUM_W   = CNT_W + $clog2(TOP_RUNS + 1);
	localparam int RATIO_W = RATIO_FRAC_BITS + 1;
	localparam int ITER_W  = $clog2(RATIO_FRAC_BITS);
	localparam int ROW_W   = 12;
	localparam int PIX_W   = 8;
	localparam int ROWS_W  = 13;
	localparam int ROWS_RESET = 480;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef logic [CNT_W-1:0] cnt_t;
	typedef cnt_t [TOP_RUNS-1:0] runs_t;

	typedef struct packed {
		logic hit;
		logic last;
	} cls_t;

	typedef struct packed {
		cnt_t  hits;
		runs_t runs;
	} line_sum_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_SUM,
		DIV_ITER,
		DIV_HOLD
	} div_state_t;

	function automatic cnt_t sat_inc(cnt_t v);
		return (v < CNT_W'(MAX_LINE_PIXELS)) ? v + cnt_t'(1) : CNT_W'(MAX_LINE_PIXELS);
	endfunction

	// Insert len into a descending list; no change if it beats no entry.
	function automatic runs_t insert_run(runs_t r, cnt_t len);
		runs_t o;
		logic [TOP_RUNS-1:0] gt;
		for (int i = 0; i < TOP_RUNS; i++) gt[i] = len > r[i];
		o[0] = gt[0] ? len : r[0];
		for (int i = 1; i < TOP_RUNS; i++) begin
			if (!gt[i]) o[i] = r[i];
			else if (!gt[i-1]) o[i] = len;
			else o[i] = r[i-1];
		end
		return o;
	endfunction
endpackage

@@ rtl/lerr_front.sv @@
// Front end: takes pixel items, holds the row count, classifies hits.
module lerr_front import lerr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [ROW_W-1:0]  row_pos,
	input  logic [PIX_W-1:0]  pix_center,
	input  logic [PIX_W-1:0]  pix_below,
	input  logic [PIX_W-1:0]  pix_above,
	input  logic              last_pixel,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [ROWS_W-1:0] cfg_data,
	output logic              q_push,
	output cls_t              q_data,
	input  logic              q_full
);
	logic [ROWS_W-1:0] image_rows_q;
	logic [ROWS_W-1:0] row_c, row_b, row_a;
	logic              hit_c, hit_b, hit_a, accept;
	logic              valid_s1;
	cls_t              cls_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_rows_q <= ROWS_W'(ROWS_RESET);
		end else if (cfg_valid) begin
			image_rows_q <= cfg_data;
		end
	end

	always_comb begin
		row_c = ROWS_W'(row_pos);
		row_b = row_c + ROWS_W'(1);
		row_a = row_c - ROWS_W'(1);
		hit_c = (row_c < image_rows_q) && (pix_center != '0);
		hit_b = (row_b < image_rows_q) && (pix_below != '0);
		hit_a = (row_pos != '0) && (row_a < image_rows_q) && (pix_above != '0);
	end

	assign full   = valid_s1 && q_full;
	assign accept = push && !full;
	assign q_push = valid_s1 && !q_full;
	assign q_data = cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cls_s1.hit  <= hit_c || hit_b || hit_a;
			cls_s1.last <= last_pixel;
		end
	end
endmodule

@@ rtl/lerr_queue.sv @@
// Short queue of classified pixels between front and back.
module lerr_queue import lerr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic q_push,
	input  cls_t q_data,
	output logic q_full,
	input  logic q_pop,
	output cls_t q_head,
	output logic q_empty
);
	cls_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign q_full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign q_empty = count_q == '0;
	assign q_head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (q_push) begin
			mem_q[wr_ptr_q] <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (q_push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (q_pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			unique case ({q_push, q_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

@@ rtl/lerr_back.sv @@
// Back end: hit count, current run and the longest runs of the line.
module lerr_back import lerr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cls_t      q_head,
	input  logic      q_empty,
	output logic      q_pop,
	input  logic      div_ready,
	output logic      div_start,
	output line_sum_t div_data
);
	cnt_t  run_q, hits_q, next_run, next_hits, ins_len;
	runs_t runs_q, runs_n;

	assign q_pop     = !q_empty && (!q_head.last || div_ready);
	assign div_start = q_pop && q_head.last;

	always_comb begin
		next_run  = q_head.hit ? sat_inc(run_q) : '0;
		next_hits = q_head.hit ? sat_inc(hits_q) : hits_q;
		// run ends on a miss, or is still open on the last pixel
		ins_len   = q_head.hit ? (q_head.last ? next_run : '0) : run_q;
		runs_n    = insert_run(runs_q, ins_len);
		div_data.hits = next_hits;
		div_data.runs = runs_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= '0;
			hits_q <= '0;
			runs_q <= '0;
		end else if (q_pop) begin
			if (q_head.last) begin
				run_q  <= '0;
				hits_q <= '0;
				runs_q <= '0;
			end else begin
				run_q  <= next_run;
				hits_q <= next_hits;
				runs_q <= runs_n;
			end
		end
	end
endmodule

@@ rtl/lerr_div.sv @@
// Line result: run sum and a bit-serial ratio divider, held until popped.
module lerr_div import lerr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               div_start,
	input  line_sum_t          div_data,
	output logic               div_ready,
	output logic               empty,
	input  logic               pop,
	output logic [CNT_W-1:0]   hit_total,
	output logic [CNT_W-1:0]   top_runs_sum,
	output logic [RATIO_W-1:0] run_ratio
);
	div_state_t          state_q, state_n;
	cnt_t                hits_q, sum_q, rem_q, sum_sat;
	runs_t               runs_q;
	logic [SUM_W-1:0]    sum_raw;
	logic [CNT_W:0]      shifted;
	logic                ge, special;
	logic [ITER_W-1:0]   cnt_q;
	logic [RATIO_W-1:0]  ratio_q;

	always_comb begin
		sum_raw = '0;
		for (int i = 0; i < TOP_RUNS; i++) sum_raw = sum_raw + SUM_W'(runs_q[i]);
		sum_sat = (sum_raw > SUM_W'(MAX_LINE_PIXELS)) ? CNT_W'(MAX_LINE_PIXELS)
		                                              : sum_raw[CNT_W-1:0];
		shifted = {rem_q, 1'b0};
		ge      = shifted >= {1'b0, hits_q};
		special = (hits_q == '0) || (sum_q >= hits_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= DIV_IDLE;
		else state_q <= state_n;
	end

	always_comb begin
		state_n   = state_q;
		div_ready = 1'b0;
		empty     = 1'b1;
		unique case (state_q)
			DIV_IDLE: begin
				div_ready = 1'b1;
				if (div_start) state_n = DIV_SUM;
			end
			DIV_SUM: state_n = DIV_ITER;
			DIV_ITER: begin
				if (special || cnt_q == ITER_W'(RATIO_FRAC_BITS - 1)) state_n = DIV_HOLD;
			end
			DIV_HOLD: begin
				empty = 1'b0;
				if (pop) state_n = DIV_IDLE;
			end
			default: state_n = DIV_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			DIV_IDLE: begin
				if (div_start) begin
					hits_q <= div_data.hits;
					runs_q <= div_data.runs;
				end
			end
			DIV_SUM: begin
				sum_q   <= sum_sat;
				rem_q   <= sum_sat;
				ratio_q <= '0;
				cnt_q   <= '0;
			end
			DIV_ITER: begin
				if (special) begin
					ratio_q <= (hits_q == '0) ? '0 : RATIO_W'(1) << RATIO_FRAC_BITS;
				end else begin
					ratio_q <= {ratio_q[RATIO_W-2:0], ge};
					rem_q   <= ge ? CNT_W'(shifted - {1'b0, hits_q}) : shifted[CNT_W-1:0];
					cnt_q   <= cnt_q + ITER_W'(1);
				end
			end
			default: ;
		endcase
	end

	assign hit_total    = hits_q;
	assign top_runs_sum = sum_q;
	assign run_ratio    = ratio_q;
endmodule

@@ rtl/line_edge_run_ratio.sv @@
// Top level of the line edge run ratio block.
//
//  channel   handshake             payload
//  pixels    push / full           row_pos, pix_center, pix_below, pix_above, last_pixel
//  results   pop / empty           hit_total, top_runs_sum, run_ratio
//  config    cfg_valid / cfg_ready cfg_data (image_rows)
//
// One pixel item per cycle is taken while full is low;
// a four-entry queue parts classify from run tracking. The divider sums the runs, then
// makes one quotient bit a cycle, stopping at once when the ratio comes out 0 or 1.0;
// a last pixel waits in the queue while the divider is busy.
// A finished result holds the divider until it is popped.
// Reset clears line state and sets image_rows to 480.
`include "assert_macros.svh"
module line_edge_run_ratio import lerr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [ROW_W-1:0]   row_pos,
	input  logic [PIX_W-1:0]   pix_center,
	input  logic [PIX_W-1:0]   pix_below,
	input  logic [PIX_W-1:0]   pix_above,
	input  logic               last_pixel,
	output logic               empty,
	input  logic               pop,
	output logic [CNT_W-1:0]   hit_total,
	output logic [CNT_W-1:0]   top_runs_sum,
	output logic [RATIO_W-1:0] run_ratio,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [ROWS_W-1:0]  cfg_data
);
	cls_t      q_data, q_head;
	logic      q_push, q_full, q_pop, q_empty;
	logic      div_ready, div_start;
	line_sum_t div_data;

	lerr_front u_front (
		.clk, .arst_n, .push, .full, .row_pos, .pix_center, .pix_below, .pix_above,
		.last_pixel, .cfg_valid, .cfg_ready, .cfg_data, .q_push, .q_data, .q_full
	);

	lerr_queue u_queue (
		.clk, .arst_n, .q_push, .q_data, .q_full, .q_pop, .q_head, .q_empty
	);

	lerr_back u_back (
		.clk, .arst_n, .q_head, .q_empty, .q_pop, .div_ready, .div_start, .div_data
	);

	lerr_div u_div (
		.clk, .arst_n, .div_start, .div_data, .div_ready, .empty, .pop,
		.hit_total, .top_runs_sum, .run_ratio
	);

	`LERR_ASSERT_ALWAYS(a_ratio_range, empty || run_ratio <= (RATIO_W'(1) << RATIO_FRAC_BITS))
	`LERR_ASSERT_ALWAYS(a_sum_le_hits, empty || top_runs_sum <= hit_total)
	`LERR_ASSERT_ALWAYS(a_zero_hits, empty || hit_total != '0 || run_ratio == '0)
	`LERR_ASSERT_NEXT(a_pop_frees, pop && !empty, empty)
endmodule

@@ tb/line_edge_run_ratio_tb.sv @@
// Testbench for line_edge_run_ratio: directed and random lines checked against a run-score predictor.
module line_edge_run_ratio_tb;
	import lerr_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 40;
	localparam int REPORT_MAX    = 10;

	typedef struct {
		cnt_t               hits;
		cnt_t               runs_sum;
		logic [RATIO_W-1:0] ratio;
	} line_score_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic [ROW_W-1:0]   row_pos = '0;
	logic [PIX_W-1:0]   pix_center = '0;
	logic [PIX_W-1:0]   pix_below = '0;
	logic [PIX_W-1:0]   pix_above = '0;
	logic               last_pixel = 1'b0;
	logic               empty;
	logic               pop = 1'b0;
	logic [CNT_W-1:0]   hit_total;
	logic [CNT_W-1:0]   top_runs_sum;
	logic [RATIO_W-1:0] run_ratio;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [ROWS_W-1:0]  cfg_data = '0;

	line_score_t pending_scores[$];
	int          rows_cfg = ROWS_RESET;
	int          run_len = 0;
	int          hit_cnt = 0;
	int          best_runs[TOP_RUNS];
	int          score_errors = 0;
	int          cycle_count = 0;
	int          rx_hold_req = 0;
	bit          steady = 1'b0;

	line_edge_run_ratio dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.row_pos(row_pos),
		.pix_center(pix_center),
		.pix_below(pix_below),
		.pix_above(pix_above),
		.last_pixel(last_pixel),
		.empty(empty),
		.pop(pop),
		.hit_total(hit_total),
		.top_runs_sum(top_runs_sum),
		.run_ratio(run_ratio),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom % 100;
		if (steady || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic int bump(int v);
		return (v < MAX_LINE_PIXELS) ? v + 1 : MAX_LINE_PIXELS;
	endfunction

	task automatic rank_run(int len);
		int pos;
		pos = TOP_RUNS;
		for (int i = TOP_RUNS - 1; i >= 0; i--)
			if (len > best_runs[i])
				pos = i;
		if (pos < TOP_RUNS) begin
			for (int i = TOP_RUNS - 1; i > pos; i--)
				best_runs[i] = best_runs[i-1];
			best_runs[pos] = len;
		end
	endtask

	task automatic track_pixel(input int r, input int c, input int b, input int a, input bit last);
		bit          hit;
		int          total;
		longint      q;
		line_score_t s;
		hit = (r < rows_cfg && c != 0) || (r + 1 < rows_cfg && b != 0) ||
			(r >= 1 && r - 1 < rows_cfg && a != 0);
		if (hit) begin
			hit_cnt = bump(hit_cnt);
			run_len = bump(run_len);
		end else if (run_len > 0) begin
			rank_run(run_len);
			run_len = 0;
		end
		if (!last)
			return;
		if (run_len > 0)
			rank_run(run_len);
		total = 0;
		foreach (best_runs[i])
			total += best_runs[i];
		if (total > MAX_LINE_PIXELS)
			total = MAX_LINE_PIXELS;
		q = 0;
		if (hit_cnt != 0) begin
			q = (longint'(total) << RATIO_FRAC_BITS) / hit_cnt;
			if (q > (longint'(1) << RATIO_FRAC_BITS))
				q = longint'(1) << RATIO_FRAC_BITS;
		end
		s.hits = cnt_t'(hit_cnt);
		s.runs_sum = cnt_t'(total);
		s.ratio = RATIO_W'(q);
		pending_scores = {pending_scores, s};
		run_len = 0;
		hit_cnt = 0;
		foreach (best_runs[i])
			best_runs[i] = 0;
	endtask

	// push is left high when the next item follows at once
	task automatic send_pixel(input int r, input int c, input int b, input int a, input bit last);
		int gap;
		bit taken;
		push <= 1'b1;
		row_pos <= ROW_W'(r);
		pix_center <= PIX_W'(c);
		pix_below <= PIX_W'(b);
		pix_above <= PIX_W'(a);
		last_pixel <= last;
		do begin
			@(negedge clk);
			taken = !full;
			@(posedge clk);
		end while (!taken);
		track_pixel(r, c, b, a, last);
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hit runs of the given lengths split by single misses, last item closes the line
	task automatic send_runs(input int lens[$]);
		foreach (lens[i]) begin
			for (int k = 0; k < lens[i]; k++)
				send_pixel($urandom_range(1, 400), $urandom_range(1, 255), 0, 0,
					i == lens.size() - 1 && k == lens[i] - 1);
			if (i != lens.size() - 1)
				send_pixel($urandom_range(1, 400), 0, 0, 0, 1'b0);
		end
	endtask

	task automatic settle();
		push <= 1'b0;
		while (pending_scores.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_image_rows(input int v);
		cfg_valid <= 1'b1;
		cfg_data <= ROWS_W'(v);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		rows_cfg = v;
	endtask

	task automatic test_row_bounds();
		send_pixel(0, 0, 0, 9, 1'b0);
		send_pixel(0, 5, 0, 0, 1'b0);
		send_pixel(ROWS_RESET - 1, 0, 7, 0, 1'b0);
		send_pixel(ROWS_RESET - 1, 0, 0, 255, 1'b0);
		send_pixel(ROWS_RESET, 255, 255, 0, 1'b0);
		send_pixel(ROWS_RESET, 0, 0, 1, 1'b0);
		send_pixel(4095, 255, 255, 255, 1'b0);
		send_pixel(12, 0, 128, 0, 1'b1);
	endtask

	task automatic test_empty_and_single_lines();
		send_pixel(100, 0, 0, 0, 1'b0);
		send_pixel(4095, 255, 255, 255, 1'b1);
		send_pixel(200, 0, 0, 64, 1'b1);
	endtask

	task automatic test_run_ranking();
		send_runs('{2, 1, 3, 1, 4});
	endtask

	task automatic test_image_rows_extremes();
		settle();
		write_image_rows(1);
		send_pixel(0, 3, 0, 0, 1'b0);
		send_pixel(0, 0, 3, 0, 1'b0);
		send_pixel(1, 0, 0, 3, 1'b0);
		send_pixel(1, 3, 3, 0, 1'b0);
		send_pixel(0, 0, 0, 0, 1'b1);
		settle();
		write_image_rows(4096);
		send_pixel(4095, 0, 9, 0, 1'b0);
		send_pixel(4095, 9, 0, 0, 1'b0);
		send_pixel(4095, 0, 0, 9, 1'b1);
		settle();
		write_image_rows(8191);
		send_pixel(4095, 0, 200, 0, 1'b1);
		settle();
		write_image_rows(0);
		send_pixel(5, 1, 1, 1, 1'b0);
		send_pixel(0, 255, 255, 255, 1'b1);
		settle();
		write_image_rows(ROWS_RESET);
	endtask

	task automatic test_full_stall();
		steady = 1'b1;
		rx_hold_req = 400;
		for (int i = 0; i < 10; i++)
			send_runs('{$urandom_range(1, 3)});
		steady = 1'b0;
		settle();
	endtask

	function automatic int pick_row();
		int top;
		top = (rows_cfg > 4096) ? 4095 : rows_cfg - 1;
		if (top < 0)
			top = 0;
		if ($urandom % 100 < 75)
			return $urandom_range(0, top);
		case ($urandom % 6)
			0: return 0;
			1: return top;
			2: return (top + 1 > 4095) ? 4095 : top + 1;
			3: return (top > 0) ? top - 1 : 0;
			4: return 4095;
			default: return $urandom_range(0, 4095);
		endcase
	endfunction

	function automatic int pick_level(int zero_pct);
		return ($urandom % 100 < zero_pct) ? 0 : $urandom_range(1, 255);
	endfunction

	task automatic test_random_lines();
		int phase_rows[7];
		int budget;
		int sent;
		int len;
		int zp;
		int r;
		phase_rows = '{ROWS_RESET, 1, 4096, 8191, $urandom_range(2, 4095), 0, ROWS_RESET};
		foreach (phase_rows[p]) begin
			settle();
			write_image_rows(phase_rows[p]);
			budget = (phase_rows[p] == 0) ? 60 : 200;
			sent = 0;
			while (sent < budget) begin
				r = $urandom % 100;
				len = (r < 75) ? $urandom_range(1, 12) :
					(r < 97) ? $urandom_range(13, 48) : $urandom_range(49, 300);
				case ($urandom % 4)
					0: zp = 10;
					1: zp = 30;
					2: zp = 70;
					default: zp = 95;
				endcase
				steady = ($urandom % 100 < 15);
				for (int k = 0; k < len; k++)
					send_pixel(pick_row(), pick_level(zp), pick_level(zp), pick_level(zp),
						k == len - 1);
				sent += len;
			end
			steady = 1'b0;
		end
	endtask

	initial begin : result_checker
		line_score_t e;
		int          hold_left;
		int          stall_left;
		hold_left = 0;
		stall_left = 0;
		wait (arst_n);
		forever begin
			// outputs and pop only change at the rising edge
			@(negedge clk);
			if (pop && !empty) begin
				if (pending_scores.size() == 0) begin
					score_errors++;
					if (score_errors <= REPORT_MAX)
						$display("unexpected result: hits %0d sum %0d ratio %0d",
							hit_total, top_runs_sum, run_ratio);
				end else begin
					e = pending_scores.pop_front();
					if (hit_total !== e.hits || top_runs_sum !== e.runs_sum ||
						run_ratio !== e.ratio) begin
						score_errors++;
						if (score_errors <= REPORT_MAX)
							$display("mismatch: exp hits %0d sum %0d ratio %0d, got %0d %0d %0d",
								e.hits, e.runs_sum, e.ratio, hit_total, top_runs_sum,
								run_ratio);
					end
				end
			end
			@(posedge clk);
			if (rx_hold_req > 0) begin
				hold_left = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	initial begin
		foreach (best_runs[i])
			best_runs[i] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_row_bounds();
		test_empty_and_single_lines();
		test_run_ranking();
		test_image_rows_extremes();
		test_full_stall();
		test_random_lines();
		settle();
		if (score_errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
